@@ rtl/radio_spur_mitigation_calc_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the spur mitigation calculator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIO_SPUR_MITIGATION_CALC_ASSERT_SVH
`define RADIO_SPUR_MITIGATION_CALC_ASSERT_SVH

// Same-cycle implication
`define RSMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RSMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsmc_pkg
// Constants and lookup functions for the spur mitigation calculator.
// ----------------------------------------------------------------------------
package rsmc_pkg;

  localparam int FREQ_W      = 13;
  localparam int CODE_W      = 8;
  localparam int TABLE_BYTES = 5;
  localparam int TABLE_W     = TABLE_BYTES * CODE_W;

  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 72;

  // register indexes
  localparam logic REG_TABLE_2G = 1'b0;
  localparam logic REG_TABLE_5G = 1'b1;

  // OFDM outcome codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_DIS  = 2'd1;
  localparam logic [1:0] ACT_EN   = 2'd2;

  localparam logic [2:0] AGC_LIMIT_ON  = 3'd7;
  localparam logic [2:0] AGC_LIMIT_OFF = 3'd5;

  localparam logic [FREQ_W-1:0] BASE_2G = 13'd2300;
  localparam logic [FREQ_W-1:0] BASE_5G = 13'd4900;

  localparam logic [FREQ_W-1:0] CCK_SPURS [4] = '{13'd2420, 13'd2440, 13'd2464, 13'd2480};

  // |d| * 524288 / 11, |d| up to 9
  function automatic logic [18:0] cck_mag(logic [3:0] k);
    logic [18:0] m;
    unique case (k)
      4'd0:    m = '0;
      4'd1:    m = 19'(524288 * 1 / 11);
      4'd2:    m = 19'(524288 * 2 / 11);
      4'd3:    m = 19'(524288 * 3 / 11);
      4'd4:    m = 19'(524288 * 4 / 11);
      4'd5:    m = 19'(524288 * 5 / 11);
      4'd6:    m = 19'(524288 * 6 / 11);
      4'd7:    m = 19'(524288 * 7 / 11);
      4'd8:    m = 19'(524288 * 8 / 11);
      4'd9:    m = 19'(524288 * 9 / 11);
      default: m = '0;
    endcase
    return m;
  endfunction

  // k * 131072 / 5, k up to 18 (20 MHz mode feeds 2*|off|)
  function automatic logic [18:0] dphase_mag(logic [4:0] k);
    logic [18:0] m;
    unique case (k)
      5'd0:    m = '0;
      5'd1:    m = 19'(131072 * 1 / 5);
      5'd2:    m = 19'(131072 * 2 / 5);
      5'd3:    m = 19'(131072 * 3 / 5);
      5'd4:    m = 19'(131072 * 4 / 5);
      5'd5:    m = 19'(131072 * 5 / 5);
      5'd6:    m = 19'(131072 * 6 / 5);
      5'd7:    m = 19'(131072 * 7 / 5);
      5'd8:    m = 19'(131072 * 8 / 5);
      5'd9:    m = 19'(131072 * 9 / 5);
      5'd10:   m = 19'(131072 * 10 / 5);
      5'd11:   m = 19'(131072 * 11 / 5);
      5'd12:   m = 19'(131072 * 12 / 5);
      5'd13:   m = 19'(131072 * 13 / 5);
      5'd14:   m = 19'(131072 * 14 / 5);
      5'd15:   m = 19'(131072 * 15 / 5);
      5'd16:   m = 19'(131072 * 16 / 5);
      5'd17:   m = 19'(131072 * 17 / 5);
      5'd18:   m = 19'(131072 * 18 / 5);
      default: m = '0;
    endcase
    return m;
  endfunction

  // k * 512 / 11, k up to 10
  function automatic logic [8:0] fstep_mag(logic [3:0] k);
    logic [8:0] m;
    unique case (k)
      4'd0:    m = '0;
      4'd1:    m = 9'(512 * 1 / 11);
      4'd2:    m = 9'(512 * 2 / 11);
      4'd3:    m = 9'(512 * 3 / 11);
      4'd4:    m = 9'(512 * 4 / 11);
      4'd5:    m = 9'(512 * 5 / 11);
      4'd6:    m = 9'(512 * 6 / 11);
      4'd7:    m = 9'(512 * 7 / 11);
      4'd8:    m = 9'(512 * 8 / 11);
      4'd9:    m = 9'(512 * 9 / 11);
      4'd10:   m = 9'(512 * 10 / 11);
      default: m = '0;
    endcase
    return m;
  endfunction

  // k * 16 / 5, k up to 18
  function automatic logic [5:0] mask_mag(logic [4:0] k);
    logic [5:0] m;
    unique case (k)
      5'd0:    m = '0;
      5'd1:    m = 6'(16 * 1 / 5);
      5'd2:    m = 6'(16 * 2 / 5);
      5'd3:    m = 6'(16 * 3 / 5);
      5'd4:    m = 6'(16 * 4 / 5);
      5'd5:    m = 6'(16 * 5 / 5);
      5'd6:    m = 6'(16 * 6 / 5);
      5'd7:    m = 6'(16 * 7 / 5);
      5'd8:    m = 6'(16 * 8 / 5);
      5'd9:    m = 6'(16 * 9 / 5);
      5'd10:   m = 6'(16 * 10 / 5);
      5'd11:   m = 6'(16 * 11 / 5);
      5'd12:   m = 6'(16 * 12 / 5);
      5'd13:   m = 6'(16 * 13 / 5);
      5'd14:   m = 6'(16 * 14 / 5);
      5'd15:   m = 6'(16 * 15 / 5);
      5'd16:   m = 6'(16 * 16 / 5);
      5'd17:   m = 6'(16 * 17 / 5);
      5'd18:   m = 6'(16 * 18 / 5);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/radio_spur_mitigation_calc.sv @@
// ----------------------------------------------------------------------------
// radio_spur_mitigation_calc
// Three register stages lie between input accept and result valid.
// Throughput: one channel item per cycle; stall propagates back stage by stage.
// Reset (rst_n low, synchronous): pipeline emptied, both spur tables cleared.
// Config writes are taken every cycle (cfg_ready tied high).
// ----------------------------------------------------------------------------
`include "radio_spur_mitigation_calc_assert.svh"

module radio_spur_mitigation_calc #(
  parameter int SPUR_ENTRIES = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [rsmc_pkg::TABLE_W-1:0]        cfg_data,
  // channel item in
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // chan_freq_mhz[12:0], band_is_2ghz[13], wide_40mhz[14], ext_above[15],
  // dynamic_mode[16], zero pad [23:17]
  input  logic [rsmc_pkg::IN_DATA_W-1:0]      in_tdata,
  // result item out
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cck_enable[0], cck_agc_limit[3:1], cck_spur_freq[23:4], ofdm_action[25:24],
  // delta_phase[45:26], freq_step[55:46], subchannel_bit[56],
  // nf_rssi_enable[57], mask_index[64:58], zero pad [71:65]
  output logic [rsmc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Entries past the register's five bytes read as zero and end the list,
  // so only the first min(SPUR_ENTRIES, 5) entries need hardware.
  localparam int NUM_ACT = (SPUR_ENTRIES < rsmc_pkg::TABLE_BYTES) ?
                           SPUR_ENTRIES : rsmc_pkg::TABLE_BYTES;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rsmc_pkg::TABLE_W-1:0] tbl_2g_r;
  logic [rsmc_pkg::TABLE_W-1:0] tbl_5g_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_2g_r <= '0;
      tbl_5g_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rsmc_pkg::REG_TABLE_2G: tbl_2g_r <= cfg_data;
        rsmc_pkg::REG_TABLE_5G: tbl_5g_r <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage advance: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, out_valid_r;
  logic ld1, ld2, ld3;

  assign ld3       = !out_valid_r || out_tready;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;

  // --------------------------------------------------------------------------
  // Stage 1: window tests for every CCK spur and every table entry
  // --------------------------------------------------------------------------
  logic [rsmc_pkg::FREQ_W-1:0] in_freq;
  logic                        in_band_2g, in_wide, in_above, in_dyn;

  assign in_freq    = in_tdata[12:0];
  assign in_band_2g = in_tdata[13];
  assign in_wide    = in_tdata[14];
  assign in_above   = in_tdata[15];
  assign in_dyn     = in_tdata[16];

  logic signed [14:0]          freq_s, centre, rng, cck_dif, spur_dif;
  logic [rsmc_pkg::TABLE_W-1:0] tbl_sel;
  logic [rsmc_pkg::CODE_W-1:0] code;
  logic [rsmc_pkg::FREQ_W-1:0] spur_f;
  logic                        live;

  logic [3:0]          s1_cck_hit_nxt;
  logic signed [4:0]   s1_cck_d_nxt [4];
  logic [NUM_ACT-1:0]  s1_hit_nxt;
  logic signed [5:0]   s1_sofs_nxt [NUM_ACT];
  logic                s1_empty_nxt;

  always_comb begin
    freq_s = $signed({2'b00, in_freq});
    centre = freq_s;
    if (in_wide) begin
      centre = in_above ? (freq_s + 15'sd10) : (freq_s - 15'sd10);
    end
    rng = in_wide ? 15'sd19 : 15'sd10;

    // CCK: each list frequency tested on its own, first hit picked later
    cck_dif = '0;
    for (int j = 0; j < 4; j++) begin
      cck_dif           = $signed({2'b00, rsmc_pkg::CCK_SPURS[j]}) - freq_s;
      s1_cck_hit_nxt[j] = (cck_dif > -15'sd10) && (cck_dif < 15'sd10);
      s1_cck_d_nxt[j]   = cck_dif[4:0];
    end

    // OFDM: decode codes; a zero code kills this and all later entries
    tbl_sel      = in_band_2g ? tbl_2g_r : tbl_5g_r;
    s1_empty_nxt = (tbl_sel[7:0] == '0);
    live         = 1'b1;
    code         = '0;
    spur_f       = '0;
    spur_dif     = '0;
    for (int i = 0; i < NUM_ACT; i++) begin
      code   = tbl_sel[8*i +: 8];
      live   = live && (code != '0);
      spur_f = in_band_2g ? (rsmc_pkg::BASE_2G + {5'b0, code})
                          : (rsmc_pkg::BASE_5G + {3'b0, code, 2'b00} + {5'b0, code});
      spur_dif       = $signed({2'b00, spur_f}) - centre;
      s1_hit_nxt[i]  = live && (spur_dif > -rng) && (spur_dif < rng);
      s1_sofs_nxt[i] = spur_dif[5:0];
    end
  end

  logic [3:0]          s1_cck_hit_r;
  logic signed [4:0]   s1_cck_d_r [4];
  logic [NUM_ACT-1:0]  s1_hit_r;
  logic signed [5:0]   s1_sofs_r [NUM_ACT];
  logic                s1_empty_r, s1_wide_r, s1_above_r, s1_dyn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_tvalid) begin
      s1_cck_hit_r <= s1_cck_hit_nxt;
      s1_cck_d_r   <= s1_cck_d_nxt;
      s1_hit_r     <= s1_hit_nxt;
      s1_sofs_r    <= s1_sofs_nxt;
      s1_empty_r   <= s1_empty_nxt;
      s1_wide_r    <= in_wide;
      s1_above_r   <= in_above;
      s1_dyn_r     <= in_dyn;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the first hit in list order
  // --------------------------------------------------------------------------
  logic              s2_cck_en_nxt, s2_found_nxt;
  logic signed [4:0] s2_cck_d_nxt;
  logic signed [5:0] s2_sofs_nxt;
  logic [1:0]        s2_action_nxt;

  always_comb begin
    s2_cck_en_nxt = 1'b0;
    s2_cck_d_nxt  = '0;
    for (int j = 0; j < 4; j++) begin
      if (!s2_cck_en_nxt && s1_cck_hit_r[j]) begin
        s2_cck_en_nxt = 1'b1;
        s2_cck_d_nxt  = s1_cck_d_r[j];
      end
    end

    s2_found_nxt = 1'b0;
    s2_sofs_nxt  = '0;
    for (int i = 0; i < NUM_ACT; i++) begin
      if (!s2_found_nxt && s1_hit_r[i]) begin
        s2_found_nxt = 1'b1;
        s2_sofs_nxt  = s1_sofs_r[i];
      end
    end

    priority if (s1_empty_r) begin
      s2_action_nxt = rsmc_pkg::ACT_NONE;
    end else if (s2_found_nxt) begin
      s2_action_nxt = rsmc_pkg::ACT_EN;
    end else begin
      s2_action_nxt = rsmc_pkg::ACT_DIS;
    end
  end

  logic              s2_cck_en_r, s2_wide_r, s2_above_r, s2_dyn_r;
  logic signed [4:0] s2_cck_d_r;
  logic signed [5:0] s2_sofs_r;
  logic [1:0]        s2_action_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      s2_cck_en_r <= s2_cck_en_nxt;
      s2_cck_d_r  <= s2_cck_d_nxt;
      s2_sofs_r   <= s2_sofs_nxt;
      s2_action_r <= s2_action_nxt;
      s2_wide_r   <= s1_wide_r;
      s2_above_r  <= s1_above_r;
      s2_dyn_r    <= s1_dyn_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale offsets through constant tables, apply sign, zero unused
  // --------------------------------------------------------------------------
  logic              ofdm_en, sofs_neg, off_neg;
  logic [3:0]        cck_k, off_k;
  logic [4:0]        sofs_k, dph_k;
  logic signed [5:0] off6;
  logic [19:0]       cck_m20, dph_m20;
  logic [9:0]        fst_m10;
  logic [6:0]        msk_m7;

  logic              out_cck_en_nxt, out_subch_nxt, out_nf_nxt;
  logic [2:0]        out_agc_nxt;
  logic signed [19:0] out_cck_freq_nxt, out_dphase_nxt;
  logic signed [9:0] out_fstep_nxt;
  logic signed [6:0] out_mask_nxt;

  always_comb begin
    ofdm_en  = (s2_action_r == rsmc_pkg::ACT_EN);

    // CCK
    cck_k    = s2_cck_d_r[4] ? 4'(-s2_cck_d_r) : s2_cck_d_r[3:0];
    cck_m20  = {1'b0, rsmc_pkg::cck_mag(cck_k)};
    out_cck_en_nxt   = s2_cck_en_r;
    out_agc_nxt      = s2_cck_en_r ? rsmc_pkg::AGC_LIMIT_ON : rsmc_pkg::AGC_LIMIT_OFF;
    out_cck_freq_nxt = !s2_cck_en_r ? '0 :
                       (s2_cck_d_r[4] ? -$signed(cck_m20) : $signed(cck_m20));

    // OFDM spur offset from centre
    sofs_neg = s2_sofs_r[5];
    sofs_k   = sofs_neg ? 5'(-s2_sofs_r) : s2_sofs_r[4:0];

    // 20 MHz mode scales by 262144/5, i.e. the 131072/5 table at twice the offset
    dph_k    = s2_wide_r ? sofs_k : {sofs_k[3:0], 1'b0};
    dph_m20  = {1'b0, rsmc_pkg::dphase_mag(dph_k)};

    // 40 MHz mode: step is measured from the subchannel centre
    off6 = s2_sofs_r;
    if (s2_wide_r) begin
      off6 = sofs_neg ? (s2_sofs_r + 6'sd10) : (s2_sofs_r - 6'sd10);
    end
    off_neg = off6[5];
    off_k   = off_neg ? 4'(-off6) : off6[3:0];
    fst_m10 = {1'b0, rsmc_pkg::fstep_mag(off_k)};

    msk_m7  = {1'b0, rsmc_pkg::mask_mag(sofs_k)};

    out_dphase_nxt = '0;
    out_fstep_nxt  = '0;
    out_subch_nxt  = 1'b0;
    out_nf_nxt     = 1'b0;
    out_mask_nxt   = '0;
    if (ofdm_en) begin
      out_dphase_nxt = sofs_neg ? -$signed(dph_m20) : $signed(dph_m20);
      out_fstep_nxt  = off_neg ? -$signed(fst_m10) : $signed(fst_m10);
      out_subch_nxt  = s2_wide_r && (sofs_neg ? !s2_above_r : s2_above_r);
      out_nf_nxt     = s2_dyn_r;
      // negative quotient takes one more off: -q - 1 == ~q
      out_mask_nxt   = sofs_neg ? $signed(~msk_m7) : $signed(msk_m7);
    end
  end

  logic              out_cck_en_r, out_subch_r, out_nf_r;
  logic [2:0]        out_agc_r;
  logic signed [19:0] out_cck_freq_r, out_dphase_r;
  logic [1:0]        out_action_r;
  logic signed [9:0] out_fstep_r;
  logic signed [6:0] out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld3) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      out_cck_en_r   <= out_cck_en_nxt;
      out_agc_r      <= out_agc_nxt;
      out_cck_freq_r <= out_cck_freq_nxt;
      out_action_r   <= s2_action_r;
      out_dphase_r   <= out_dphase_nxt;
      out_fstep_r    <= out_fstep_nxt;
      out_subch_r    <= out_subch_nxt;
      out_nf_r       <= out_nf_nxt;
      out_mask_r     <= out_mask_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_mask_r, out_nf_r, out_subch_r, out_fstep_r,
                       out_dphase_r, out_action_r, out_cck_freq_r, out_agc_r,
                       out_cck_en_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RSMC_ASSERT_NXT(a_accept_fills_s1, in_tvalid && in_tready, v1_r, "accepted item lost at stage 1")
  `RSMC_ASSERT_NXT(a_s2_holds, v2_r && !ld3, v2_r && $stable(s2_sofs_r) && $stable(s2_action_r), "stage 2 changed under stall")
  `RSMC_ASSERT_NOW(a_empty_no_hit, v1_r && s1_empty_r, s1_hit_r == '0, "hit reported on empty spur table")
  `RSMC_ASSERT_NOW(a_unused_zero, out_valid_r && (out_action_r != rsmc_pkg::ACT_EN), (out_dphase_r == '0) && (out_fstep_r == '0) && (out_mask_r == '0) && !out_subch_r && !out_nf_r, "OFDM fields set without mitigation")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spur mitigation calculator testbench
// Channel items are streamed into the block and every result item is
// checked, field by field and in order, against settings that a scoreboard
// predicts from the channel and its own copy of the two spur tables. The
// tables are rewritten between phases while the pipeline is empty, and each
// phase runs under one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import rsmc_pkg::*;

  localparam int NUM_SPUR_ENTRIES = 5;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 235;
  localparam int HOLD_CYCLES      = 64;
  // pipeline is three stages deep; give it a little more before table writes
  localparam int DRAIN_CYCLES     = 6;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              is2g;
    logic              wide;
    logic              above;
    logic              dyn;
  } channel_t;

  typedef struct packed {
    logic        cck_en;
    logic [2:0]  agc;
    logic [19:0] cck_freq;
    logic [1:0]  action;
    logic [19:0] dphase;
    logic [9:0]  fstep;
    logic        subch;
    logic        nf;
    logic [6:0]  mask;
  } spur_settings_t;

  // Predicts the spur-filter settings of each channel item and holds them
  // until the matching result item comes out.
  class spur_scoreboard;
    logic [TABLE_W-1:0] table_2g;
    logic [TABLE_W-1:0] table_5g;
    spur_settings_t     pending_settings[$];
    int                 cck_spur_mhz[4];
    int                 errors;
    int                 results_seen;
    int                 cck_on_seen;
    int                 ofdm_on_seen;

    function new();
      cck_spur_mhz = '{2420, 2440, 2464, 2480};
      table_2g     = '0;
      table_5g     = '0;
      errors       = 0;
      results_seen = 0;
      cck_on_seen  = 0;
      ofdm_on_seen = 0;
    endfunction

    function void write_table(logic idx, logic [TABLE_W-1:0] val);
      if (idx == REG_TABLE_2G) table_2g = val;
      else table_5g = val;
    endfunction

    function spur_settings_t predict_settings(channel_t c);
      spur_settings_t     s;
      logic [TABLE_W-1:0] tbl;
      int                 f, d, centre, window, spur, shifted, code, q, i;
      bit                 hit, done;
      s.cck_en   = 1'b0;
      s.agc      = AGC_LIMIT_OFF;
      s.cck_freq = '0;
      s.action   = ACT_NONE;
      s.dphase   = '0;
      s.fstep    = '0;
      s.subch    = 1'b0;
      s.nf       = 1'b0;
      s.mask     = '0;
      f = int'(c.freq);

      // CCK: first listed spur closer than 10 MHz wins
      foreach (cck_spur_mhz[k]) begin
        d = cck_spur_mhz[k] - f;
        if (!s.cck_en && d > -10 && d < 10) begin
          s.cck_en   = 1'b1;
          s.agc      = AGC_LIMIT_ON;
          s.cck_freq = 20'(d * 524288 / 11);
        end
      end

      // OFDM: an empty table leaves the settings untouched
      tbl  = c.is2g ? table_2g : table_5g;
      hit  = 1'b0;
      done = 1'b0;
      spur = 0;
      if (tbl[7:0] != 8'd0) begin
        s.action = ACT_DIS;
        centre   = f;
        window   = 10;
        if (c.wide) begin
          window = 19;
          centre = c.above ? f + 10 : f - 10;
        end
        for (i = 0; i < NUM_SPUR_ENTRIES && i < TABLE_BYTES; i++) begin
          code = int'(tbl[8*i +: 8]);
          if (code == 0) done = 1'b1;
          if (!done && !hit) begin
            spur = (c.is2g ? 2300 + code : 4900 + 5 * code) - centre;
            if (spur > -window && spur < window) hit = 1'b1;
          end
        end
        if (hit) begin
          s.action = ACT_EN;
          if (c.wide) begin
            s.dphase = 20'(spur * 131072 / 5);
            if (spur < 0) begin
              s.subch = !c.above;
              shifted = spur + 10;
            end else begin
              s.subch = c.above;
              shifted = spur - 10;
            end
          end else begin
            s.dphase = 20'(spur * 262144 / 5);
            shifted  = spur;
          end
          s.fstep = 10'(shifted * 512 / 11);
          s.nf    = c.dyn;
          q = spur * 16 / 5;
          if (q < 0) q = q - 1;
          s.mask = 7'(q);
        end
      end
      return s;
    endfunction

    function void note_channel(channel_t c);
      pending_settings.push_back(predict_settings(c));
    endfunction

    function void compare_field(string name, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      spur_settings_t want;
      if (pending_settings.size() == 0) begin
        $error("result item 0x%0h arrived with no channel item outstanding", d);
        errors++;
      end else begin
        want = pending_settings.pop_front();
        results_seen++;
        if (want.cck_en) cck_on_seen++;
        if (want.action == ACT_EN) ofdm_on_seen++;
        compare_field("cck_enable",     20'(want.cck_en), 20'(d[0]));
        compare_field("cck_agc_limit",  20'(want.agc),    20'(d[3:1]));
        compare_field("cck_spur_freq",  want.cck_freq,    d[23:4]);
        compare_field("ofdm_action",    20'(want.action), 20'(d[25:24]));
        compare_field("delta_phase",    want.dphase,      d[45:26]);
        compare_field("freq_step",      20'(want.fstep),  20'(d[55:46]));
        compare_field("subchannel_bit", 20'(want.subch),  20'(d[56]));
        compare_field("nf_rssi_enable", 20'(want.nf),     20'(d[57]));
        compare_field("mask_index",     20'(want.mask),   20'(d[64:58]));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [TABLE_W-1:0]    cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  spur_scoreboard sb;
  int             cycle_count    = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  bit             hold_request   = 1'b0;
  int             hold_left;

  radio_spur_mitigation_calc #(
    .SPUR_ENTRIES(NUM_SPUR_ENTRIES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still outstanding",
             cycle_count, sb.pending_settings.size());
      $display("radio_spur_mitigation_calc verification failed");
      $finish;
    end
  end

  // Receiver: drive out_tready at the falling edge. A hold request from the
  // stimulus side starts a long stall that is counted down here, so the
  // pipeline fills and pushes back on the sender.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every result item taken at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Offer one channel item, idling first at the configured rate; return in
  // the time step of the rising edge that accepted it.
  task automatic send_channel(channel_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_DATA_W - 17){1'b0}}, c.dyn, c.above, c.wide, c.is2g, c.freq};
    do @(posedge clk); while (!in_tready);
    sb.note_channel(c);
  endtask

  // Stop offering, wait until every expected result has come, then let the
  // pipeline settle. Returns on a rising edge.
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_settings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table(logic idx, logic [TABLE_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_table(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic channel_t chan(int freq, bit is2g, bit wide, bit above, bit dyn);
    channel_t c;
    c.freq  = FREQ_W'(freq);
    c.is2g  = is2g;
    c.wide  = wide;
    c.above = above;
    c.dyn   = dyn;
    return c;
  endfunction

  // Mostly channels aimed near a listed spur, so the windows, edges and both
  // sides of the centre get exercised; the rest is any 13-bit frequency.
  function automatic channel_t random_channel();
    channel_t           c;
    logic [TABLE_W-1:0] tbl;
    int                 pick, slot, code, base;
    c.is2g  = 1'($urandom_range(1));
    c.wide  = 1'($urandom_range(1));
    c.above = 1'($urandom_range(1));
    c.dyn   = 1'($urandom_range(1));
    pick    = $urandom_range(99);
    if (pick < 10) begin
      c.freq = FREQ_W'($urandom_range(8191));
    end else if (pick < 35) begin
      c.is2g = ($urandom_range(3) != 0);
      slot   = $urandom_range(3);
      c.freq = FREQ_W'(sb.cck_spur_mhz[slot] + int'($urandom_range(24)) - 12);
    end else begin
      tbl  = c.is2g ? sb.table_2g : sb.table_5g;
      slot = $urandom_range(TABLE_BYTES - 1);
      code = int'(tbl[8*slot +: 8]);
      if (code == 0) code = $urandom_range(1, 255);
      base   = c.is2g ? 2300 + code : 4900 + 5 * code;
      c.freq = FREQ_W'(base + int'($urandom_range(60)) - 30);
    end
    return c;
  endfunction

  // Random table: each code is zero now and then, which cuts the list short.
  function automatic logic [TABLE_W-1:0] random_table();
    logic [TABLE_W-1:0] t;
    int                 b;
    for (b = 0; b < TABLE_BYTES; b++) begin
      t[8*b +: 8] = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    end
    return t;
  endfunction

  initial begin
    int phase;
    int n;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TABLE_2G;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. 2.4 GHz codes: 2420, 2440, 2555, 2301, end.
    // 5 GHz codes: 4905, 6175, 5400, 5200, 5540.
    write_table(REG_TABLE_2G, 40'h00_01_FF_8C_78);
    write_table(REG_TABLE_5G, 40'h80_3C_64_FF_01);
    send_channel(chan(0,    1, 0, 0, 0));  // lowest frequency, no spur anywhere
    send_channel(chan(8191, 1, 1, 1, 1));  // highest frequency, every flag set
    send_channel(chan(2420, 1, 0, 0, 1));  // exact CCK and OFDM hit
    send_channel(chan(2411, 1, 0, 0, 0));  // CCK offset +9, window edge inside
    send_channel(chan(2429, 1, 0, 1, 0));  // offset -9; ext side ignored at 20 MHz
    send_channel(chan(2410, 1, 0, 0, 0));  // offset 10: just outside both
    send_channel(chan(2472, 1, 0, 0, 0));  // two CCK spurs in range, first wins
    send_channel(chan(2489, 1, 0, 0, 0));
    send_channel(chan(2490, 1, 0, 0, 0));
    send_channel(chan(2430, 1, 1, 1, 0));  // 40 MHz, centre up, spur on centre
    send_channel(chan(2450, 1, 1, 0, 1));  // 40 MHz, centre down, spur on centre
    send_channel(chan(2448, 1, 1, 1, 0));  // spur 18 below the centre
    send_channel(chan(2412, 1, 1, 0, 0));  // spur 18 above the centre
    send_channel(chan(2391, 1, 1, 1, 0));  // spur 19 away: outside the wide window
    send_channel(chan(2564, 1, 0, 1, 1));  // top 2.4 GHz code
    send_channel(chan(2301, 1, 0, 0, 0));  // hit on the last live entry
    send_channel(chan(6175, 0, 0, 0, 1));  // top 5 GHz code
    send_channel(chan(6166, 0, 0, 0, 0));
    send_channel(chan(6185, 0, 0, 0, 0));
    send_channel(chan(5400, 0, 1, 1, 0));  // spur 10 below centre, other subchannel
    send_channel(chan(5380, 0, 1, 1, 1));  // spur 10 above centre
    send_channel(chan(5540, 0, 1, 0, 0));  // hit on the fifth entry
    send_channel(chan(4900, 0, 0, 0, 0));
    send_channel(chan(2300, 0, 0, 0, 0));  // 2.4 GHz channel against 5 GHz table

    // Empty 2.4 GHz table despite later codes; 5 GHz list cut short by a zero.
    drain_pipeline();
    write_table(REG_TABLE_2G, 40'hFF_FF_FF_FF_00);
    write_table(REG_TABLE_5G, 40'h00_00_78_00_01);
    send_channel(chan(2420, 1, 0, 0, 1));
    send_channel(chan(5500, 0, 0, 0, 0));  // code hidden behind the end marker
    send_channel(chan(4905, 0, 1, 1, 0));

    // Random part: a fresh table setting and idling pattern per phase.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_pipeline();
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      if (phase == 0) begin
        write_table(REG_TABLE_2G, '0);
        write_table(REG_TABLE_5G, '0);
      end else if (phase == 1) begin
        write_table(REG_TABLE_2G, '1);
        write_table(REG_TABLE_5G, '1);
      end else begin
        write_table(REG_TABLE_2G, random_table());
        write_table(REG_TABLE_5G, random_table());
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_channel(random_channel());
        // back-pressure: receiver holds off while items keep coming
        if (n == 100 && phase % 4 == 0) hold_request = 1'b1;
        // sender pause until every outstanding result has come
        if (n == 160) drain_pipeline();
      end
    end

    drain_pipeline();
    $display("Covered %0d channel items over %0d spur-table settings and four idling patterns;",
             sb.results_seen, NUM_PHASES + 2);
    $display("  %0d results had the CCK filter on, %0d had OFDM mitigation on.",
             sb.cck_on_seen, sb.ofdm_on_seen);
    if (sb.errors == 0) begin
      $display("radio_spur_mitigation_calc verification clean");
    end else begin
      $display("radio_spur_mitigation_calc verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rsmc_pkg.sv
rtl/radio_spur_mitigation_calc.sv
sim/testbench.sv
